// ===== src/bbd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the bilinear Bayer demosaic: widths, register defaults,
// register indexes and the geometry clamp. No dependencies.
package bbd_pkg;

   localparam int DIM_W          = 13;
   localparam int POS_W          = 12;
   localparam int CH_W           = 16;
   localparam int SAMPLE_W       = 16;
   localparam int CSR_IDX_W      = 2;

   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [DIM_W-1:0] DEF_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] DEF_HEIGHT = DIM_W'(480);
   localparam logic [DIM_W-1:0] MIN_DIM    = DIM_W'(4);
   localparam int               DIM_LIMIT  = 8190;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH      = 2'd0,
      CSR_HEIGHT     = 2'd1,
      CSR_SWAP_BLUE  = 2'd2,
      CSR_SWAP_GREEN = 2'd3
   } csr_index_type;

   // clear the low bit, then clamp into [MIN_DIM, top]
   function automatic logic [DIM_W-1:0] even_clamp(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] top);
      logic [DIM_W-1:0] x;
      x = {v[DIM_W-1:1], 1'b0};
      if (x < MIN_DIM) x = MIN_DIM;
      if (x > top) x = top;
      return x;
   endfunction

endpackage

// ===== src/bayer_bilinear_demosaic_top.sv =====
`timescale 1ns / 1ps
// Streaming bilinear Bayer demosaic: two line stores, a 3x3 window, one
// interpolation stage and a result register that replays border copies. Uses bbd_pkg.
// The item passes through the input register into the result register, which loads only
// when it is free. Throughput: one item per cycle when the output does not stall;
// a border item yields 2 or 4 results and stalls the input until the last of them is taken.
// Reset (synchronous): counters to zero, 640 x 480, swaps off; line stores not cleared.
module bayer_bilinear_demosaic_top #(
   parameter int MAX_WIDTH   = bbd_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = bbd_pkg::SAMPLE_BITS_DEF,
   parameter int MAX_HEIGHT  = bbd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bbd_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bbd_pkg::POS_W-1:0]      rsp_out_row,
   output logic [bbd_pkg::POS_W-1:0]      rsp_out_col,
   output logic [bbd_pkg::CH_W-1:0]       rsp_blue,
   output logic [bbd_pkg::CH_W-1:0]       rsp_green,
   output logic [bbd_pkg::CH_W-1:0]       rsp_red,
   output logic                           rsp_last_of_run,
   output logic                           rsp_frame_done,
   input  logic                           csr_write_en,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bbd_pkg::DIM_W-1:0]      csr_wdata
);
   import bbd_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int SB   = SAMPLE_BITS;
   localparam int DCW  = (CW > DIM_W) ? CW : DIM_W;
   localparam int DRW  = (RW > DIM_W) ? RW : DIM_W;
   localparam int W_EVEN = MAX_WIDTH - (MAX_WIDTH % 2);
   localparam int H_EVEN = MAX_HEIGHT - (MAX_HEIGHT % 2);
   localparam logic [DIM_W-1:0] W_TOP = DIM_W'((W_EVEN > DIM_LIMIT) ? DIM_LIMIT : W_EVEN);
   localparam logic [DIM_W-1:0] H_TOP = DIM_W'((H_EVEN > DIM_LIMIT) ? DIM_LIMIT : H_EVEN);

   // configuration and position
   logic [DIM_W-1:0] width_ff, height_ff;
   logic             swap_blue_ff, swap_green_ff;
   logic [CW-1:0]    col_cnt_ff;
   logic [RW-1:0]    row_cnt_ff;
   logic [DIM_W-1:0] width_m1, height_m1;
   logic             col_end, row_end;

   // line stores
   logic [SB-1:0]    store_a [MAX_WIDTH];
   logic [SB-1:0]    store_b [MAX_WIDTH];
   logic [SB-1:0]    rd_a_ff, rd_b_ff;
   logic             wr_b_ff;

   // input register
   logic             s1_valid_ff;
   logic [SB-1:0]    s1_sample_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [RW-1:0]    s1_row_ff;

   // window
   logic [SB-1:0]    win_ff [9];
   logic [SB-1:0]    win_in [9];

   // result register
   logic             e_valid_ff;
   logic [SB-1:0]    e_blue_ff, e_green_ff, e_red_ff;
   logic [CW-1:0]    e_pc_ff;
   logic [RW-1:0]    e_pr_ff;
   logic             e_col_lo_ff, e_col_hi_ff, e_row_lo_ff, e_row_hi_ff;
   logic             e_ci_ff, e_ri_ff;

   logic             req_acc, rsp_acc, out_last, out_free, adv1, emits1, load_e;
   logic [SB-1:0]    sample_m;
   logic [SB-1:0]    blue_in, green_in, red_in;
   logic [SB:0]      sum_h, sum_v;
   logic [SB+1:0]    sum_x, sum_d;
   logic             rowtype, green_site;
   logic [CW-1:0]    col_v;
   logic [RW-1:0]    row_v;

   assign sample_m  = req_sample[SB-1:0];
   assign width_m1  = width_ff - DIM_W'(1);
   assign height_m1 = height_ff - DIM_W'(1);
   assign col_end   = (DCW'(col_cnt_ff) == DCW'(width_m1));
   assign row_end   = (DRW'(row_cnt_ff) == DRW'(height_m1));

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = e_valid_ff && !rsp_stall;
   assign out_last  = (e_ci_ff == (e_col_lo_ff | e_col_hi_ff)) &&
                      (e_ri_ff == (e_row_lo_ff | e_row_hi_ff));
   assign out_free  = !e_valid_ff || (rsp_acc && out_last);
   assign emits1    = (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));
   assign adv1      = s1_valid_ff && (!emits1 || out_free);
   assign load_e    = adv1 && emits1;
   assign req_stall = reset || (s1_valid_ff && !adv1);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= DEF_WIDTH;
         height_ff     <= DEF_HEIGHT;
         swap_blue_ff  <= 1'b0;
         swap_green_ff <= 1'b0;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               width_ff   <= even_clamp(csr_wdata, W_TOP);
               col_cnt_ff <= '0;
               row_cnt_ff <= '0;
            end
            CSR_HEIGHT: begin
               height_ff  <= even_clamp(csr_wdata, H_TOP);
               col_cnt_ff <= '0;
               row_cnt_ff <= '0;
            end
            CSR_SWAP_BLUE:  swap_blue_ff  <= csr_wdata[0];
            CSR_SWAP_GREEN: swap_green_ff <= csr_wdata[0];
            default: ;
         endcase
      end else if (req_acc) begin
         if (col_end) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= row_end ? '0 : row_cnt_ff + RW'(1);
         end else begin
            col_cnt_ff <= col_cnt_ff + CW'(1);
         end
      end
   end

   // read before write: store_b takes the old row of store_a in the following cycle
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_a_ff              <= store_a[col_cnt_ff];
         rd_b_ff              <= store_b[col_cnt_ff];
         store_a[col_cnt_ff]  <= sample_m;
      end
      if (wr_b_ff) begin
         store_b[s1_col_ff] <= rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_b_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         wr_b_ff <= req_acc;
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (adv1) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_sample_ff <= sample_m;
         s1_col_ff    <= col_cnt_ff;
         s1_row_ff    <= row_cnt_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]     = win_ff[i*3+1];
         win_in[i*3 + 1] = win_ff[i*3+2];
      end
      win_in[2] = rd_b_ff;
      win_in[5] = rd_a_ff;
      win_in[8] = s1_sample_ff;
   end

   always_comb begin
      sum_h = {1'b0, win_in[3]} + {1'b0, win_in[5]} + (SB+1)'(1);
      sum_v = {1'b0, win_in[1]} + {1'b0, win_in[7]} + (SB+1)'(1);
      sum_x = (SB+2)'(win_in[1]) + (SB+2)'(win_in[3]) + (SB+2)'(win_in[5]) +
              (SB+2)'(win_in[7]) + (SB+2)'(2);
      sum_d = (SB+2)'(win_in[0]) + (SB+2)'(win_in[2]) + (SB+2)'(win_in[6]) +
              (SB+2)'(win_in[8]) + (SB+2)'(2);
      // rowtype 0: G R row, 1: B G row (row and column of the pixel are one less)
      rowtype    = (~s1_row_ff[0]) ^ swap_green_ff;
      green_site = ((~s1_col_ff[0]) == rowtype);
      if (green_site) begin
         green_in = win_in[4];
         if (!rowtype) begin
            red_in  = sum_h[SB:1];
            blue_in = sum_v[SB:1];
         end else begin
            blue_in = sum_h[SB:1];
            red_in  = sum_v[SB:1];
         end
      end else begin
         green_in = sum_x[SB+1:2];
         if (!rowtype) begin
            red_in  = win_in[4];
            blue_in = sum_d[SB+1:2];
         end else begin
            blue_in = win_in[4];
            red_in  = sum_d[SB+1:2];
         end
      end
      if (swap_blue_ff) begin
         {blue_in, red_in} = {red_in, blue_in};
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
      if (load_e) begin
         e_blue_ff   <= blue_in;
         e_green_ff  <= green_in;
         e_red_ff    <= red_in;
         e_pc_ff     <= s1_col_ff - CW'(1);
         e_pr_ff     <= s1_row_ff - RW'(1);
         e_col_lo_ff <= (s1_col_ff == CW'(2));
         e_col_hi_ff <= (DCW'(s1_col_ff) == DCW'(width_m1));
         e_row_lo_ff <= (s1_row_ff == RW'(2));
         e_row_hi_ff <= (DRW'(s1_row_ff) == DRW'(height_m1));
      end
   end

   // walk the border copies: columns outer, rows inner
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         e_ci_ff    <= 1'b0;
         e_ri_ff    <= 1'b0;
      end else if (load_e) begin
         e_valid_ff <= 1'b1;
         e_ci_ff    <= 1'b0;
         e_ri_ff    <= 1'b0;
      end else if (rsp_acc) begin
         if (out_last) begin
            e_valid_ff <= 1'b0;
         end else if (!e_ri_ff && (e_row_lo_ff || e_row_hi_ff)) begin
            e_ri_ff <= 1'b1;
         end else begin
            e_ri_ff <= 1'b0;
            e_ci_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      if (!e_ci_ff) begin
         col_v = e_col_lo_ff ? '0 : e_pc_ff;
      end else begin
         col_v = e_col_lo_ff ? e_pc_ff : e_pc_ff + CW'(1);
      end
      if (!e_ri_ff) begin
         row_v = e_row_lo_ff ? '0 : e_pr_ff;
      end else begin
         row_v = e_row_lo_ff ? e_pr_ff : e_pr_ff + RW'(1);
      end
   end

   assign rsp_valid       = e_valid_ff;
   assign rsp_out_row     = POS_W'(row_v);
   assign rsp_out_col     = POS_W'(col_v);
   assign rsp_blue        = CH_W'(e_blue_ff);
   assign rsp_green       = CH_W'(e_green_ff);
   assign rsp_red         = CH_W'(e_red_ff);
   assign rsp_last_of_run = out_last;
   assign rsp_frame_done  = (DRW'(row_v) == DRW'(height_m1)) &&
                            (DCW'(col_v) == DCW'(width_m1));

endmodule
